[hdl/pbkdf_pkg.sv]
// Shared types, constants and SHA-256 helper functions for the PBKDF2 key derivation block.
`default_nettype none
package pbkdf_pkg;

    // Request codes carried by req_type
    localparam logic [1:0] REQ_PASSWORD = 2'd0;
    localparam logic [1:0] REQ_SALT     = 2'd1;
    localparam logic [1:0] REQ_START    = 2'd2;

    // Register indexes on the configuration port
    localparam logic REG_ITERATIONS = 1'b0;
    localparam logic REG_KEY_LENGTH = 1'b1;

    localparam logic [31:0] ITERATIONS_RESET = 32'd10000;
    localparam logic [6:0]  KEY_LENGTH_RESET = 7'd32;

    localparam logic [7:0] IPAD_BYTE = 8'h36;
    localparam logic [7:0] OPAD_BYTE = 8'h5c;

    // SHA-256 initial hash value, word 0 in the top bits
    localparam logic [255:0] SHA_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Sequencer states
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_LOADH = 6'b000010,
        ST_FILL  = 6'b000100,
        ST_ROUND = 6'b001000,
        ST_FIN   = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    // Hash jobs the sequencer runs through
    typedef enum logic [2:0] {
        JOB_KIPAD,
        JOB_KOPAD,
        JOB_SALT,
        JOB_CHAIN,
        JOB_OUTER
    } job_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // Round constants
    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        round_k = k;
    endfunction

endpackage
`default_nettype wire

[hdl/pbkdf_req_if.sv]
// Request channel: request code and byte, valid/ready handshake.
`default_nettype none
interface pbkdf_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] byte_value;

    modport source (output valid, output req_type, output byte_value, input ready);
    modport sink (input valid, input req_type, input byte_value, output ready);
endinterface
`default_nettype wire

[hdl/pbkdf_key_if.sv]
// Key channel: derived key bytes with last mark and status, valid/ready handshake.
`default_nettype none
interface pbkdf_key_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_byte;
    logic       last_byte;
    logic       status;

    modport source (output valid, output key_byte, output last_byte, output status, input ready);
    modport sink (input valid, input key_byte, input last_byte, input status, output ready);
endinterface
`default_nettype wire

[hdl/pbkdf2_hmac_sha256_kdf_top.sv]
// PBKDF2-HMAC-SHA256 key derivation: byte stores, one shared SHA-256 round unit, sequencer.
// Load beats (password or salt byte) are accepted while idle; the block stays ready after each one.
// A start beat runs SHA-256 compressions (load, fill, rounds, finish; no load step for a second
// block of one message): two for the key pads, then per key block (inner salt blocks + 1)
// plus 2*(iteration_count-1) more; then each key byte is registered and held until it is taken.
// Reset (rst_n low, async) clears counts, overflow flag, sequencer and registers to defaults.
`default_nettype none
module pbkdf2_hmac_sha256_kdf_top #(
    parameter int MAX_PASSWORD_BYTES = 64,
    parameter int MAX_SALT_BYTES     = 64,
    parameter int MAX_KEY_BYTES      = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    pbkdf_req_if.sink        req,
    pbkdf_key_if.source      key,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import pbkdf_pkg::*;

    localparam int PW_AW = (MAX_PASSWORD_BYTES > 1) ? $clog2(MAX_PASSWORD_BYTES) : 1;
    localparam int SA_AW = (MAX_SALT_BYTES > 1) ? $clog2(MAX_SALT_BYTES) : 1;
    localparam int PC_W  = $clog2(MAX_PASSWORD_BYTES + 1);
    localparam int SC_W  = $clog2(MAX_SALT_BYTES + 1);

    // Configuration registers
    logic [31:0] iterations_reg;
    logic [6:0]  key_length_reg;

    // Stores and counts
    logic [7:0]      pw_mem [MAX_PASSWORD_BYTES];
    logic [7:0]      salt_mem [MAX_SALT_BYTES];
    logic [7:0]      pw_rd_reg;
    logic [7:0]      salt_rd_reg;
    logic [PC_W-1:0] pw_count_reg;
    logic [SC_W-1:0] salt_count_reg;
    logic            overflow_reg;

    // Sequencer
    state_t      state_reg;
    job_t        job_reg;
    logic [7:0]  pos_reg;
    logic [7:0]  q_reg;
    logic        dv_reg;
    logic [6:0]  iss_reg;
    logic [5:0]  shf_reg;
    logic [5:0]  rnd_reg;
    logic [31:0] iter_reg;
    logic        first_reg;
    logic        blk2_reg;
    logic [6:0]  out_idx_reg;
    logic [6:0]  n_reg;
    logic        status_reg;

    // Hash datapath
    logic [511:0] win_reg;
    logic [255:0] h_reg;
    logic [31:0]  v_reg [8];
    logic [255:0] kps0_reg;
    logic [255:0] kps1_reg;
    logic [255:0] inner_reg;
    logic [255:0] chain_reg;
    logic [255:0] acc_reg;

    // Output register
    logic       ov_reg;
    logic [7:0] key_byte_reg;
    logic       last_reg;
    logic       stat_out_reg;

    logic        in_acc;
    logic        out_acc;
    logic        cfg_wr;
    logic [7:0]  msg_len;
    logic [8:0]  tot_bytes;
    logic [15:0] bit_len;
    logic [7:0]  fill_byte;
    logic [7:0]  pw_cnt8;
    logic [7:0]  salt_cnt8;
    logic [7:0]  idx_off;
    logic [255:0] src_dig;
    logic [255:0] h_sum;
    logic [31:0] w0, w1, w9, w14, w_new, t1, t2, ch, maj;
    logic [31:0] iter_eff;
    logic [6:0]  n_eff;
    logic        job_end;

    assign in_acc  = req.valid & req.ready;
    assign out_acc = ov_reg & key.ready;
    assign cfg_wr  = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_KEY_LENGTH) ? {25'd0, key_length_reg} : iterations_reg;

    assign req.ready     = (state_reg == ST_IDLE);
    assign key.valid     = ov_reg;
    assign key.key_byte  = key_byte_reg;
    assign key.last_byte = last_reg;
    assign key.status    = stat_out_reg;

    assign pw_cnt8   = {{(8-PC_W){1'b0}}, pw_count_reg};
    assign salt_cnt8 = {{(8-SC_W){1'b0}}, salt_count_reg};
    assign iter_eff  = (iterations_reg == 32'd0) ? 32'd1 : iterations_reg;
    assign n_eff     = (key_length_reg == 7'd0) ? 7'd1 :
                       (key_length_reg > 7'(MAX_KEY_BYTES)) ? 7'(MAX_KEY_BYTES) : key_length_reg;

    // Message byte generator for the current job and delayed position
    always_comb
    begin
        msg_len   = (job_reg == JOB_SALT) ? salt_cnt8 + 8'd4 : 8'd32;
        tot_bytes = (job_reg == JOB_KIPAD || job_reg == JOB_KOPAD) ? 9'd64 :
                    (((9'(msg_len) + 9'd72) >> 6) << 6);
        bit_len   = (16'(msg_len) + 16'd64) << 3;
        src_dig   = (job_reg == JOB_CHAIN) ? chain_reg : inner_reg;
        idx_off   = q_reg - salt_cnt8;
        fill_byte = 8'h00;
        case (job_reg)
            JOB_KIPAD: fill_byte = ((q_reg < pw_cnt8) ? pw_rd_reg : 8'h00) ^ IPAD_BYTE;
            JOB_KOPAD: fill_byte = ((q_reg < pw_cnt8) ? pw_rd_reg : 8'h00) ^ OPAD_BYTE;
            default:
            begin
                if (q_reg < msg_len)
                begin
                    if (job_reg != JOB_SALT)
                        fill_byte = src_dig[{~q_reg[4:0], 3'b111} -: 8];
                    else if (q_reg < salt_cnt8)
                        fill_byte = salt_rd_reg;
                    else if (idx_off[1:0] == 2'd3)
                        fill_byte = blk2_reg ? 8'd2 : 8'd1;
                    else
                        fill_byte = 8'h00;
                end
                else if (q_reg == msg_len)
                    fill_byte = 8'h80;
                else if (9'(q_reg) == tot_bytes - 9'd1)
                    fill_byte = bit_len[7:0];
                else if (9'(q_reg) == tot_bytes - 9'd2)
                    fill_byte = bit_len[15:8];
                else
                    fill_byte = 8'h00;
            end
        endcase
    end

    // Round unit and message schedule
    always_comb
    begin
        w0    = win_reg[511:480];
        w1    = win_reg[479:448];
        w9    = win_reg[223:192];
        w14   = win_reg[63:32];
        w_new = w0 + small_sigma0(w1) + w9 + small_sigma1(w14);
        ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1    = v_reg[7] + big_sigma1(v_reg[4]) + ch + round_k(rnd_reg) + w0;
        t2    = big_sigma0(v_reg[0]) + maj;
        for (int i = 0; i < 8; i++)
            h_sum[255-32*i -: 32] = h_reg[255-32*i -: 32] + v_reg[i];
        job_end = (9'(pos_reg) == tot_bytes);
    end

    // Control: configuration, counts, sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iterations_reg <= ITERATIONS_RESET;
            key_length_reg <= KEY_LENGTH_RESET;
            pw_count_reg   <= '0;
            salt_count_reg <= '0;
            overflow_reg   <= 1'b0;
            state_reg      <= ST_IDLE;
            job_reg        <= JOB_KIPAD;
            pos_reg        <= '0;
            dv_reg         <= 1'b0;
            iss_reg        <= '0;
            shf_reg        <= '0;
            rnd_reg        <= '0;
            iter_reg       <= '0;
            first_reg      <= 1'b0;
            blk2_reg       <= 1'b0;
            out_idx_reg    <= '0;
            n_reg          <= 7'd1;
            status_reg     <= 1'b0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                if (paddr[2] == REG_ITERATIONS)
                    iterations_reg <= pwdata;
                else
                    key_length_reg <= pwdata[6:0];
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (req.req_type == REQ_PASSWORD)
                        begin
                            if (pw_count_reg < PC_W'(MAX_PASSWORD_BYTES))
                                pw_count_reg <= pw_count_reg + PC_W'(1);
                            else
                                overflow_reg <= 1'b1;
                        end
                        else if (req.req_type == REQ_SALT)
                        begin
                            if (salt_count_reg < SC_W'(MAX_SALT_BYTES))
                                salt_count_reg <= salt_count_reg + SC_W'(1);
                            else
                                overflow_reg <= 1'b1;
                        end
                        else if (req.req_type == REQ_START)
                        begin
                            n_reg       <= n_eff;
                            status_reg  <= overflow_reg;
                            out_idx_reg <= '0;
                            blk2_reg    <= 1'b0;
                            job_reg     <= JOB_KIPAD;
                            state_reg   <= ST_LOADH;
                        end
                    end
                end
                ST_LOADH:
                begin
                    pos_reg   <= '0;
                    iss_reg   <= '0;
                    shf_reg   <= '0;
                    dv_reg    <= 1'b0;
                    state_reg <= ST_FILL;
                end
                ST_FILL:
                begin
                    if (iss_reg < 7'd64)
                    begin
                        pos_reg <= pos_reg + 8'd1;
                        iss_reg <= iss_reg + 7'd1;
                        dv_reg  <= 1'b1;
                    end
                    else
                        dv_reg <= 1'b0;
                    if (dv_reg)
                    begin
                        shf_reg <= shf_reg + 6'd1;
                        if (shf_reg == 6'd63)
                        begin
                            rnd_reg   <= '0;
                            state_reg <= ST_ROUND;
                        end
                    end
                end
                ST_ROUND:
                begin
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'd63)
                        state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    iss_reg <= '0;
                    shf_reg <= '0;
                    dv_reg  <= 1'b0;
                    if (!job_end)
                        state_reg <= ST_FILL;
                    else
                    begin
                        state_reg <= ST_LOADH;
                        case (job_reg)
                            JOB_KIPAD: job_reg <= JOB_KOPAD;
                            JOB_KOPAD:
                            begin
                                job_reg   <= JOB_SALT;
                                iter_reg  <= 32'd1;
                                first_reg <= 1'b1;
                            end
                            JOB_SALT, JOB_CHAIN: job_reg <= JOB_OUTER;
                            default:
                            begin
                                first_reg <= 1'b0;
                                if (iter_reg >= iter_eff)
                                    state_reg <= ST_EMIT;
                                else
                                begin
                                    iter_reg <= iter_reg + 32'd1;
                                    job_reg  <= JOB_CHAIN;
                                end
                            end
                        endcase
                    end
                end
                ST_EMIT:
                begin
                    if (!ov_reg)
                        ov_reg <= 1'b1;
                    else if (out_acc)
                    begin
                        ov_reg      <= 1'b0;
                        out_idx_reg <= out_idx_reg + 7'd1;
                        if (last_reg)
                        begin
                            pw_count_reg   <= '0;
                            salt_count_reg <= '0;
                            overflow_reg   <= 1'b0;
                            state_reg      <= ST_IDLE;
                        end
                        else if (out_idx_reg[4:0] == 5'd31)
                        begin
                            blk2_reg  <= 1'b1;
                            job_reg   <= JOB_SALT;
                            iter_reg  <= 32'd1;
                            first_reg <= 1'b1;
                            state_reg <= ST_LOADH;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Stores: write on load beats, read every cycle at the fill position
    always_ff @(posedge clk)
    begin
        if (in_acc && req.req_type == REQ_PASSWORD &&
            pw_count_reg < PC_W'(MAX_PASSWORD_BYTES))
            pw_mem[pw_count_reg[PW_AW-1:0]] <= req.byte_value;
        if (in_acc && req.req_type == REQ_SALT &&
            salt_count_reg < SC_W'(MAX_SALT_BYTES))
            salt_mem[salt_count_reg[SA_AW-1:0]] <= req.byte_value;
        pw_rd_reg   <= pw_mem[pos_reg[PW_AW-1:0]];
        salt_rd_reg <= salt_mem[pos_reg[SA_AW-1:0]];
    end

    // Hash datapath
    always_ff @(posedge clk)
    begin
        q_reg <= pos_reg;
        case (state_reg)
            ST_LOADH:
            begin
                if (job_reg == JOB_KIPAD || job_reg == JOB_KOPAD)
                    h_reg <= SHA_IV;
                else if (job_reg == JOB_OUTER)
                    h_reg <= kps1_reg;
                else
                    h_reg <= kps0_reg;
            end
            ST_FILL:
            begin
                if (dv_reg)
                    win_reg <= {win_reg[503:0], fill_byte};
                for (int i = 0; i < 8; i++)
                    v_reg[i] <= h_reg[255-32*i -: 32];
            end
            ST_ROUND:
            begin
                win_reg  <= {win_reg[479:0], w_new};
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
            end
            ST_FIN:
            begin
                h_reg <= h_sum;
                if (job_end)
                begin
                    case (job_reg)
                        JOB_KIPAD: kps0_reg <= h_sum;
                        JOB_KOPAD: kps1_reg <= h_sum;
                        JOB_SALT, JOB_CHAIN: inner_reg <= h_sum;
                        default:
                        begin
                            chain_reg <= h_sum;
                            acc_reg   <= first_reg ? h_sum : (acc_reg ^ h_sum);
                        end
                    endcase
                end
            end
            ST_EMIT:
            begin
                if (!ov_reg)
                begin
                    key_byte_reg <= acc_reg[{~out_idx_reg[4:0], 3'b111} -: 8];
                    last_reg     <= (out_idx_reg + 7'd1 == n_reg);
                    stat_out_reg <= status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

[bench/pbkdf2_hmac_sha256_kdf_top_tb.sv]
// Testbench for the PBKDF2-HMAC-SHA256 key derivation block: random loads and starts, checked per key byte.
`timescale 1ns / 100ps
module pbkdf2_hmac_sha256_kdf_top_tb;
    import pbkdf_pkg::*;

    typedef logic [7:0] u8_t;
    typedef u8_t u8_queue_t[$];

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
    } load_beat_t;

    typedef struct packed {
        logic [7:0] kbyte;
        logic       last;
        logic       ovf;
    } key_beat_t;

    localparam int MAX_PW       = 64;
    localparam int MAX_SALT     = 64;
    localparam int MAX_KEY      = 64;
    localparam int TAIL_CYCLES  = 40;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    pbkdf_req_if req_ch ();
    pbkdf_key_if key_ch ();

    pbkdf2_hmac_sha256_kdf_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .key     (key_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the block state
    logic [31:0] iter_cfg;
    logic [6:0]  klen_cfg;
    u8_queue_t   pw_bytes;
    u8_queue_t   salt_bytes;
    logic        ovf_seen;
    logic [255:0] inner_state;
    logic [255:0] outer_state;

    load_beat_t pending_beats[$];
    key_beat_t  expected_key[$];

    int  mismatches;
    int  beats_sent;
    int  starts_sent;
    int  bytes_checked;
    int  cycles;
    bit  no_idle;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // One SHA-256 compression, word 0 in the top bits
    function automatic logic [255:0] sha_block(input logic [255:0] hin, input logic [511:0] blk);
        logic [31:0] w[64];
        logic [31:0] v[8];
        logic [31:0] t1;
        logic [31:0] t2;
        logic [31:0] s0;
        logic [31:0] s1;
        logic [255:0] hout;
        int i;
        for (i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
        for (i = 16; i < 64; i++)
        begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        for (i = 0; i < 8; i++) v[i] = hin[255 - 32 * i -: 32];
        for (i = 0; i < 64; i++)
        begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(i[5:0]) + w[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (i = 0; i < 8; i++) hout[255 - 32 * i -: 32] = hin[255 - 32 * i -: 32] + v[i];
        return hout;
    endfunction

    // Finish a hash whose first 64-byte block is already folded into st
    function automatic u8_queue_t hash_tail(input logic [255:0] st, input u8_queue_t msg);
        u8_queue_t   buf_q;
        u8_queue_t   dig;
        logic [63:0] nbits;
        logic [511:0] blk;
        int i;
        int b;
        nbits = 64'(msg.size() + 64) * 8;
        buf_q = msg;
        buf_q.push_back(8'h80);
        while (buf_q.size() % 64 != 56) buf_q.push_back(8'h00);
        for (i = 7; i >= 0; i--) buf_q.push_back(nbits[8 * i +: 8]);
        for (b = 0; b < buf_q.size() / 64; b++)
        begin
            for (i = 0; i < 64; i++) blk[511 - 8 * i -: 8] = buf_q[64 * b + i];
            st = sha_block(st, blk);
        end
        for (i = 0; i < 32; i++) dig.push_back(st[255 - 8 * i -: 8]);
        return dig;
    endfunction

    function automatic u8_queue_t hmac_digest(input u8_queue_t msg);
        return hash_tail(outer_state, hash_tail(inner_state, msg));
    endfunction

    // Derive the key for a start beat and queue the expected key bytes
    task automatic derive_key();
        logic [511:0] ipad_blk;
        logic [511:0] opad_blk;
        u8_queue_t msg;
        u8_queue_t chain;
        u8_t  acc[32];
        int   n;
        int   i;
        int   k;
        logic [31:0] blk_idx;
        logic [31:0] j;
        n = (klen_cfg == 0) ? 1 : (klen_cfg > MAX_KEY) ? MAX_KEY : int'(klen_cfg);
        for (i = 0; i < 64; i++)
        begin
            ipad_blk[511 - 8 * i -: 8] = ((i < pw_bytes.size()) ? pw_bytes[i] : 8'h00) ^ 8'h36;
            opad_blk[511 - 8 * i -: 8] = ((i < pw_bytes.size()) ? pw_bytes[i] : 8'h00) ^ 8'h5c;
        end
        inner_state = sha_block(SHA_IV, ipad_blk);
        outer_state = sha_block(SHA_IV, opad_blk);
        for (i = 0; i < n; i++)
        begin
            if (i % 32 == 0)
            begin
                blk_idx = i / 32 + 1;
                msg = salt_bytes;
                for (k = 3; k >= 0; k--) msg.push_back(blk_idx[8 * k +: 8]);
                chain = hmac_digest(msg);
                for (k = 0; k < 32; k++) acc[k] = chain[k];
                for (j = 1; j < iter_cfg; j++)
                begin
                    chain = hmac_digest(chain);
                    for (k = 0; k < 32; k++) acc[k] ^= chain[k];
                end
            end
            expected_key.push_back('{kbyte: acc[i % 32], last: (i == n - 1), ovf: ovf_seen});
        end
        pw_bytes.delete();
        salt_bytes.delete();
        ovf_seen = 1'b0;
    endtask

    // Apply one accepted request beat to the shadow state
    task automatic apply_beat(input load_beat_t bt);
        case (bt.kind)
            REQ_PASSWORD:
            begin
                if (pw_bytes.size() < MAX_PW) pw_bytes.push_back(bt.value);
                else ovf_seen = 1'b1;
            end
            REQ_SALT:
            begin
                if (salt_bytes.size() < MAX_SALT) salt_bytes.push_back(bt.value);
                else ovf_seen = 1'b1;
            end
            REQ_START:
            begin
                starts_sent++;
                derive_key();
            end
            default: ;
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin : req_driver
        logic next_valid;
        load_beat_t bt;
        int gap;
        if (!rst_n)
        begin
            req_ch.valid      <= 1'b0;
            req_ch.req_type   <= REQ_PASSWORD;
            req_ch.byte_value <= 8'h00;
            gap = 0;
        end
        else
        begin
            next_valid = req_ch.valid;
            if (req_ch.valid && req_ch.ready)
            begin
                apply_beat('{kind: req_ch.req_type, value: req_ch.byte_value});
                beats_sent++;
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (gap > 0)
                    gap--;
                else if (pending_beats.size() > 0)
                begin
                    bt = pending_beats.pop_front();
                    req_ch.req_type   <= bt.kind;
                    req_ch.byte_value <= bt.value;
                    next_valid = 1'b1;
                    gap = pick_gap();
                end
            end
            req_ch.valid <= next_valid;
        end
    end

    // Key monitor and checker
    always @(posedge clk or negedge rst_n)
    begin : key_monitor
        key_beat_t want;
        int stall;
        if (!rst_n)
        begin
            key_ch.ready <= 1'b0;
            stall = 0;
        end
        else
        begin
            if (key_ch.valid && key_ch.ready)
            begin
                bytes_checked++;
                if (expected_key.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected key beat: byte %02h last %0b status %0b",
                                 key_ch.key_byte, key_ch.last_byte, key_ch.status);
                end
                else
                begin
                    want = expected_key.pop_front();
                    if (key_ch.key_byte !== want.kbyte || key_ch.last_byte !== want.last
                        || key_ch.status !== want.ovf)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("key beat mismatch: exp %02h/%0b/%0b got %02h/%0b/%0b",
                                     want.kbyte, want.last, want.ovf, key_ch.key_byte,
                                     key_ch.last_byte, key_ch.status);
                    end
                end
            end
            if (stall > 0)
            begin
                stall--;
                key_ch.ready <= 1'b0;
            end
            else
            begin
                stall = pick_gap();
                key_ch.ready <= (stall == 0);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == 3'(4 * REG_ITERATIONS)) iter_cfg = data;
        else klen_cfg = data[6:0];
    endtask

    // Wait until every queued beat is sent and every key byte has come back
    task automatic drain();
        do @(negedge clk);
        while (pending_beats.size() != 0 || req_ch.valid || expected_key.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic push_beat(input logic [1:0] kind, input logic [7:0] value);
        pending_beats.push_back('{kind: kind, value: value});
    endtask

    // One password/salt/start sequence with random content
    task automatic push_session(output int loads);
        int pw_len;
        int salt_len;
        int i;
        pw_len   = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 66) : $urandom_range(0, 10);
        salt_len = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 66) : $urandom_range(0, 12);
        loads = 0;
        for (i = 0; i < pw_len + salt_len; i++)
        begin
            // interleave password and salt bytes now and then
            if ((i < pw_len) ^ ($urandom_range(0, 7) == 0 && i < salt_len))
                push_beat(REQ_PASSWORD, 8'($urandom));
            else
                push_beat(REQ_SALT, 8'($urandom));
            if ($urandom_range(0, 19) == 0) push_beat(REQ_UNUSED, 8'($urandom));
            loads++;
        end
        // a few sequences are broken off and carry into the next one
        if ($urandom_range(0, 9) != 0)
        begin
            push_beat(REQ_START, 8'($urandom));
            loads++;
        end
    endtask

    initial
    begin : stimulus
        int issued;
        int n;
        int s;
        int r;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        iter_cfg = ITERATIONS_RESET;
        klen_cfg = KEY_LENGTH_RESET;
        ovf_seen = 1'b0;
        mismatches = 0;
        beats_sent = 0;
        starts_sent = 0;
        bytes_checked = 0;
        cycles = 0;
        no_idle = 1'b0;
        repeat (12) @(posedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Directed: register extremes, empty inputs, unused request, byte extremes
        reg_write(3'(4 * REG_ITERATIONS), 32'hFFFF_FFFF);
        reg_write(3'(4 * REG_KEY_LENGTH), 32'd0);
        reg_write(3'(4 * REG_ITERATIONS), 32'd0);
        push_beat(REQ_START, 8'hFF);
        push_beat(REQ_UNUSED, 8'hA5);
        push_beat(REQ_PASSWORD, 8'h00);
        push_beat(REQ_PASSWORD, 8'hFF);
        push_beat(REQ_SALT, 8'h00);
        push_beat(REQ_SALT, 8'hFF);
        push_beat(REQ_START, 8'h00);
        drain();
        reg_write(3'(4 * REG_KEY_LENGTH), 32'd127);
        reg_write(3'(4 * REG_ITERATIONS), 32'd2);
        push_beat(REQ_PASSWORD, 8'h5A);
        push_beat(REQ_SALT, 8'h01);
        push_beat(REQ_START, 8'h00);
        push_beat(REQ_SALT, 8'h80);
        push_beat(REQ_START, 8'h00);
        drain();

        // Random phases, each with its own register setting
        issued = 0;
        while (issued < 200)
        begin
            r = $urandom_range(0, 9);
            reg_write(3'(4 * REG_ITERATIONS), (r == 0) ? 32'd0 : 32'($urandom_range(1, 4)));
            r = $urandom_range(0, 5);
            case (r)
                0: reg_write(3'(4 * REG_KEY_LENGTH), 32'd1);
                1: reg_write(3'(4 * REG_KEY_LENGTH), 32'd64);
                2: reg_write(3'(4 * REG_KEY_LENGTH), 32'($urandom_range(65, 127)));
                default: reg_write(3'(4 * REG_KEY_LENGTH), 32'($urandom_range(0, 40)));
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            for (s = 0; s < $urandom_range(1, 3); s++)
            begin
                push_session(n);
                issued += n;
            end
            // sender holds off until the block has returned every key byte
            drain();
        end

        $display("sent %0d request beats (%0d starts), checked %0d key bytes",
                 beats_sent, starts_sent, bytes_checked);
        $display("iterations 0..4 and key lengths 0..127 exercised, %0d mismatches", mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[sim.f]
hdl/pbkdf_pkg.sv
hdl/pbkdf_req_if.sv
hdl/pbkdf_key_if.sv
hdl/pbkdf2_hmac_sha256_kdf_top.sv
bench/pbkdf2_hmac_sha256_kdf_top_tb.sv
